@@ rtl/fcw_pkg.sv @@
// fcw_pkg: shared types and constants for the FAT cluster chain walker
// transaction structs, status codes, register indexes and end-of-chain markers
// no dependencies
package fcw_pkg;

  localparam int unsigned PosW  = 48;
  localparam int unsigned ClusW = 32;
  localparam int unsigned CbW   = 20;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_UNALLOC = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_WALK  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_FAT_KIND      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_START    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROOT_START    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLUSTER_BYTES = 2'd3;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;

  localparam logic [ClusW-1:0] END_FAT12 = 32'h0000_0FF0;
  localparam logic [ClusW-1:0] END_FAT16 = 32'h0000_FFF0;
  localparam logic [ClusW-1:0] END_FAT32 = 32'h0FFF_FFF0;

  typedef struct packed {
    logic             action;
    logic [ClusW-1:0] cluster;
    logic [ClusW-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]  byte_position;
    logic [ClusW-1:0] cluster_number;
    logic [1:0]       status;
    logic             last;
    logic [ClusW-1:0] resume_cluster;
  } out_item_t;

  function automatic logic [ClusW-1:0] end_marker(input logic [1:0] kind);
    logic [ClusW-1:0] m;
    case (kind)
      KIND_FAT12: m = END_FAT12;
      KIND_FAT16: m = END_FAT16;
      default:    m = END_FAT32;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/fcw_if.sv @@
// fcw_if: valid/ready channel interfaces for items, results and register writes
// depends on fcw_pkg
interface fcw_in_if;
  logic             valid;
  logic             ready;
  fcw_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface fcw_out_if;
  logic               valid;
  logic               ready;
  fcw_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface fcw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fcw_pkg::CfgIdxW-1:0]  index;
  logic [fcw_pkg::PosW-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/fat_cluster_chain_walk.sv @@
// fat_cluster_chain_walk: FAT table store and cluster chain walker, top level
// a walk answered without a table read gives its result in the cycle after accept; a chain walk
// steps through S_READ (table data, multiply) and S_EMIT (add, emit) per cluster, stalls in S_EMIT
// on back-pressure, covers at most MAX_RUN clusters per item and is bound by the one table read port
// reset clears control and start registers, sets FAT16 and 512-byte clusters; table unset until written
// depends on fcw_pkg, fcw_if, fcw_ram
module fat_cluster_chain_walk #(
  parameter int unsigned TABLE_ENTRIES = 65536,
  parameter int unsigned MAX_RUN       = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcw_in_if.sink    in_i,
  fcw_out_if.source out_o,
  fcw_cfg_if.sink   cfg_i
);

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  localparam int unsigned RunW  = $clog2(MAX_RUN + 1);
  localparam logic [32:0] TableEnd = 33'(TABLE_ENTRIES);
  localparam logic [RunW-1:0] RunMax = RunW'(MAX_RUN);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_READ     = 4'b0010,
    S_EMIT     = 4'b0100,
    S_LINK_ERR = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]                  fat_kind_q;
  logic [fcw_pkg::PosW-1:0]    data_start_q;
  logic [fcw_pkg::PosW-1:0]    root_start_q;
  logic [fcw_pkg::CbW-1:0]     cluster_bytes_q;

  logic [fcw_pkg::ClusW-1:0]   cur_q, cur_d;
  logic [fcw_pkg::ClusW-1:0]   nx_q, nx_d;
  logic [51:0]                 mul_q, mul_d;
  logic                        first_q, first_d;
  logic [RunW-1:0]             n_q, n_d, n_next;

  fcw_pkg::out_item_t out_q, out_d;
  logic               out_valid_q;
  logic               out_load;
  logic               can_load;

  logic                      ram_we;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic [fcw_pkg::ClusW-1:0] ram_rdata;

  logic                      accept;
  logic                      in_range;
  logic                      nx_in_range;
  logic                      more;
  logic [fcw_pkg::ClusW-1:0] endm;
  logic [fcw_pkg::ClusW-1:0] off;

  fcw_ram #(
    .Width (fcw_pkg::ClusW),
    .Depth (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.item.cluster[AddrW-1:0]),
    .wdata_i (in_i.item.entry_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_kind_q      <= fcw_pkg::KIND_FAT16;
      data_start_q    <= '0;
      root_start_q    <= '0;
      cluster_bytes_q <= 20'd512;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        fcw_pkg::CFG_FAT_KIND:      fat_kind_q      <= cfg_i.data[1:0];
        fcw_pkg::CFG_DATA_START:    data_start_q    <= cfg_i.data;
        fcw_pkg::CFG_ROOT_START:    root_start_q    <= cfg_i.data;
        fcw_pkg::CFG_CLUSTER_BYTES: cluster_bytes_q <= cfg_i.data[fcw_pkg::CbW-1:0];
        default: ;
      endcase
    end
  end

  assign can_load    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && can_load;
  assign accept      = in_i.valid && in_i.ready;
  assign in_range    = {1'b0, in_i.item.cluster} < TableEnd;
  assign nx_in_range = {1'b0, nx_q} < TableEnd;
  assign endm        = fcw_pkg::end_marker(fat_kind_q);
  assign more        = (nx_q > 32'd1) && (nx_q < endm);
  assign n_next      = n_q + RunW'(1);
  assign off         = cur_q - 32'd2;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    nx_d      = nx_q;
    mul_d     = mul_q;
    first_d   = first_q;
    n_d       = n_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = cur_q[AddrW-1:0];
    out_load  = 1'b0;
    out_d     = '0;
    out_d.last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.item.action == fcw_pkg::ACT_WRITE) begin
            if (in_range) begin
              ram_we = 1'b1;
            end else begin
              out_load             = 1'b1;
              out_d.cluster_number = in_i.item.cluster;
              out_d.status         = fcw_pkg::ST_RANGE;
            end
          end else if (in_i.item.cluster == 32'd0) begin
            out_load     = 1'b1;
            out_d.status = fcw_pkg::ST_ZERO;
          end else if (in_i.item.cluster == 32'd1) begin
            out_load             = 1'b1;
            out_d.byte_position  = root_start_q;
            out_d.cluster_number = 32'd1;
            out_d.status         = fcw_pkg::ST_OK;
          end else if (!in_range) begin
            out_load             = 1'b1;
            out_d.cluster_number = in_i.item.cluster;
            out_d.status         = fcw_pkg::ST_RANGE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = in_i.item.cluster[AddrW-1:0];
            cur_d     = in_i.item.cluster;
            first_d   = 1'b1;
            n_d       = '0;
            state_d   = S_READ;
          end
        end
      end
      S_READ: begin
        nx_d    = ram_rdata;
        mul_d   = 52'(off) * 52'(cluster_bytes_q);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (can_load) begin
          out_load             = 1'b1;
          out_d.cluster_number = cur_q;
          if (first_q && (nx_q < 32'd2)) begin
            out_d.status = fcw_pkg::ST_UNALLOC;
            state_d      = S_IDLE;
          end else begin
            out_d.byte_position = data_start_q + mul_q[fcw_pkg::PosW-1:0];
            out_d.status        = fcw_pkg::ST_OK;
            first_d             = 1'b0;
            n_d                 = n_next;
            if (!more) begin
              out_d.last = 1'b1;
              state_d    = S_IDLE;
            end else if (n_next >= RunMax) begin
              out_d.last           = 1'b1;
              out_d.resume_cluster = nx_q;
              state_d              = S_IDLE;
            end else if (!nx_in_range) begin
              out_d.last = 1'b0;
              state_d    = S_LINK_ERR;
            end else begin
              out_d.last = 1'b0;
              ram_re     = 1'b1;
              ram_raddr  = nx_q[AddrW-1:0];
              cur_d      = nx_q;
              state_d    = S_READ;
            end
          end
        end
      end
      S_LINK_ERR: begin
        if (can_load) begin
          out_load             = 1'b1;
          out_d.cluster_number = nx_q;
          out_d.status         = fcw_pkg::ST_RANGE;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      n_q     <= n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nx_q  <= nx_d;
    mul_q <= mul_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

endmodule

@@ rtl/fcw_ram.sv @@
// fcw_ram: generic single-write, single-read synchronous ram, registered read data
// no dependencies
module fcw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fcw_checker.sv @@
// fcw_checker: port-level assertions for the FAT cluster chain walker, bound to the top level
// depends on fcw_pkg and fat_cluster_chain_walk
module fcw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input fcw_pkg::out_item_t out_item_i
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  // error results carry no position and end the item
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status != fcw_pkg::ST_OK) |->
      out_item_i.last && (out_item_i.byte_position == '0) &&
      (out_item_i.resume_cluster == '0))
    else $error("malformed error result");

  // a resume cluster only on the final ok result of a cut run
  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.resume_cluster != '0) |->
      out_item_i.last && (out_item_i.status == fcw_pkg::ST_OK))
    else $error("resume cluster on non-final result");

  // zero start error names cluster zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status == fcw_pkg::ST_ZERO) |->
      out_item_i.cluster_number == '0)
    else $error("zero start result with nonzero cluster");

  // no new item is taken in the middle of a walk
  a_mid_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.last |-> !in_ready_i)
    else $error("input ready during a walk");

endmodule

bind fat_cluster_chain_walk fcw_checker u_fcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.item)
);
